// File: rtl/nqp_pkg.sv
// Shared types and constants for the NVMe queue pair pointer manager.
package nqp_pkg;

  localparam int PTR_W  = 12;
  localparam int SIZE_W = 13;
  localparam int ID_W   = 16;
  localparam int CID_W  = 13;
  localparam int PTR_SPAN = 4096;
  localparam int MAX_RING_DEPTH_DEF = 4096;
  localparam int RING_MIN = 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [SIZE_W-1:0] SQ_ENTRIES_RST = 13'd64;
  localparam logic [SIZE_W-1:0] CQ_ENTRIES_RST = 13'd256;
  localparam logic [ID_W-1:0]   SQ_IDENT_RST   = 16'd1;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_ENQUEUE           = 3'd0,
    REQ_SUBMIT            = 3'd1,
    REQ_POLL              = 3'd2,
    REQ_DEQUEUE           = 3'd3,
    REQ_CQ_DOORBELL       = 3'd4,
    REQ_SQ_HEAD_CHECKED   = 3'd5,
    REQ_SQ_HEAD_UNCHECKED = 3'd6
  } req_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_BAD_QID   = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SQ_ENTRIES = 2'd0,
    CFG_CQ_ENTRIES = 2'd1,
    CFG_SQ_IDENT   = 2'd2
  } cfg_reg_t;

  // Effective configuration seen by the pointer logic.
  typedef struct packed {
    logic [SIZE_W-1:0] sq_size;
    logic [SIZE_W-1:0] cq_size;
    logic [ID_W-1:0]   sq_ident;
    logic              resize;
  } cfg_t;

  // Status of the pointer reduction unit.
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PTR_W-1:0] tail_rem;
    logic [PTR_W-1:0] head_rem;
  } reduce_stat_t;

endpackage

// File: rtl/nqp_ifs.sv
// Request and result channel interfaces of the queue pair pointer manager.
interface nqp_req_if import nqp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [2:0]      req_type;
  logic            entry_phase;
  logic            entry_present;
  logic [ID_W-1:0] entry_sqid;

  modport source (output valid, req_type, entry_phase, entry_present, entry_sqid,
                  input ready);
  modport sink (input valid, req_type, entry_phase, entry_present, entry_sqid,
                output ready);
endinterface

interface nqp_rsp_if import nqp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [PTR_W-1:0] slot_index;
  logic [CID_W-1:0] command_id;
  logic             doorbell_valid;
  logic [PTR_W-1:0] doorbell_value;

  modport source (output valid, status, slot_index, command_id, doorbell_valid,
                  doorbell_value, input ready);
  modport sink (input valid, status, slot_index, command_id, doorbell_valid,
                doorbell_value, output ready);
endinterface

// File: rtl/nqp_cfg_regs.sv
// APB configuration registers with ring size clamping.
module nqp_cfg_regs import nqp_pkg::*; #(
  parameter int MAX_RING_DEPTH = MAX_RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  localparam int LIM = (MAX_RING_DEPTH < PTR_SPAN) ? MAX_RING_DEPTH : PTR_SPAN;
  localparam logic [SIZE_W-1:0] LIM_SIZE = SIZE_W'(LIM);
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(RING_MIN);

  logic [SIZE_W-1:0] sq_entries;
  logic [SIZE_W-1:0] cq_entries;
  logic [ID_W-1:0]   sq_ident;
  logic              wr_en;
  cfg_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_entries <= SQ_ENTRIES_RST;
      cq_entries <= CQ_ENTRIES_RST;
      sq_ident   <= SQ_IDENT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        CFG_SQ_ENTRIES: sq_entries <= pwdata[SIZE_W-1:0];
        CFG_CQ_ENTRIES: cq_entries <= pwdata[SIZE_W-1:0];
        CFG_SQ_IDENT:   sq_ident   <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_sel)
      CFG_SQ_ENTRIES: prdata = APB_DATA_W'(sq_entries);
      CFG_CQ_ENTRIES: prdata = APB_DATA_W'(cq_entries);
      CFG_SQ_IDENT:   prdata = APB_DATA_W'(sq_ident);
      default:        prdata = '0;
    endcase
  end

  // Clamp ring sizes to the supported range and flag a submission resize.
  always_comb begin
    if (sq_entries < MIN_SIZE) begin
      cfg.sq_size = MIN_SIZE;
    end else if (sq_entries > LIM_SIZE) begin
      cfg.sq_size = LIM_SIZE;
    end else begin
      cfg.sq_size = sq_entries;
    end
    if (cq_entries < MIN_SIZE) begin
      cfg.cq_size = MIN_SIZE;
    end else if (cq_entries > LIM_SIZE) begin
      cfg.cq_size = LIM_SIZE;
    end else begin
      cfg.cq_size = cq_entries;
    end
    cfg.sq_ident = sq_ident;
    cfg.resize   = wr_en && (reg_sel == CFG_SQ_ENTRIES);
  end

endmodule

// File: rtl/nqp_ptr_reduce.sv
// Bit-serial remainder unit that reduces the submission pointers by the ring size.
module nqp_ptr_reduce import nqp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PTR_W-1:0]  tail_ptr,
  input  logic [PTR_W-1:0]  head_ptr,
  input  logic [SIZE_W-1:0] divisor,
  output reduce_stat_t      stat
);

  localparam int CNT_W = $clog2(PTR_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(PTR_W);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [PTR_W-1:0] rem_t;
  logic [PTR_W-1:0] rem_h;
  logic [PTR_W-1:0] dvd_t;
  logic [PTR_W-1:0] dvd_h;

  // One restoring step: bring down a bit, subtract the divisor if it fits.
  function automatic logic [PTR_W-1:0] rem_step(input logic [PTR_W-1:0] r,
                                                input logic b,
                                                input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] trial;
    logic [SIZE_W-1:0] diff;
    trial = {r, b};
    diff  = trial - n;
    if (trial >= n) begin
      return diff[PTR_W-1:0];
    end
    return trial[PTR_W-1:0];
  endfunction

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Remainder datapath for both pointers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_t <= '0;
      rem_h <= '0;
      dvd_t <= tail_ptr;
      dvd_h <= head_ptr;
    end else if (cnt != '0) begin
      rem_t <= rem_step(rem_t, dvd_t[PTR_W-1], divisor);
      rem_h <= rem_step(rem_h, dvd_h[PTR_W-1], divisor);
      dvd_t <= {dvd_t[PTR_W-2:0], 1'b0};
      dvd_h <= {dvd_h[PTR_W-2:0], 1'b0};
    end
  end

  assign stat.busy     = (cnt != '0);
  assign stat.done     = done;
  assign stat.tail_rem = rem_t;
  assign stat.head_rem = rem_h;

endmodule

// File: rtl/nqp_core.sv
// Queue pointer state, request decode and registered result stage.
module nqp_core import nqp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  reduce_stat_t     stat,
  output logic [PTR_W-1:0] tail_ptr,
  output logic [PTR_W-1:0] head_ptr,
  nqp_req_if.sink          req,
  nqp_rsp_if.source        rsp
);

  logic [PTR_W-1:0] sq_tail_ptr, sq_tail_ptr_next;
  logic [PTR_W-1:0] sq_head_ptr, sq_head_ptr_next;
  logic             sq_phase_bit, sq_phase_bit_next;
  logic [PTR_W-1:0] sq_last_rung, sq_last_rung_next;
  logic [PTR_W-1:0] cq_head_ptr, cq_head_ptr_next;
  logic             cq_phase_bit, cq_phase_bit_next;
  logic [PTR_W-1:0] cq_last_rung, cq_last_rung_next;
  logic [PTR_W-1:0] tail_mod, tail_mod_next;
  logic [PTR_W-1:0] head_mod, head_mod_next;

  logic             out_valid;
  status_t          out_status, status_c;
  logic [PTR_W-1:0] out_slot, slot_c;
  logic [CID_W-1:0] out_cid, cid_c;
  logic             out_dbv, dbv_c;
  logic [PTR_W-1:0] out_dbval, dbval_c;

  logic              req_fire;
  logic              full;
  logic [SIZE_W-1:0] tail_inc, head_inc, cq_inc, tail_mod_inc;
  logic [PTR_W-1:0]  tail_bump, head_bump, cq_bump;
  logic              tail_wrap, cq_wrap;
  logic              phase_new;

  assign req.ready = !(cfg.resize || stat.busy || stat.done) && (!out_valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign tail_ptr  = sq_tail_ptr;
  assign head_ptr  = sq_head_ptr;

  // Pointer increments that wrap to zero at the ring size.
  always_comb begin
    tail_inc  = {1'b0, sq_tail_ptr} + SIZE_W'(1);
    tail_wrap = (tail_inc >= cfg.sq_size);
    tail_bump = tail_wrap ? '0 : tail_inc[PTR_W-1:0];
    head_inc  = {1'b0, sq_head_ptr} + SIZE_W'(1);
    head_bump = (head_inc >= cfg.sq_size) ? '0 : head_inc[PTR_W-1:0];
    cq_inc    = {1'b0, cq_head_ptr} + SIZE_W'(1);
    cq_wrap   = (cq_inc >= cfg.cq_size);
    cq_bump   = cq_wrap ? '0 : cq_inc[PTR_W-1:0];
    phase_new = sq_phase_bit ^ tail_wrap;
  end

  // Full when the reduced head sits one slot past the reduced tail.
  always_comb begin
    tail_mod_inc = {1'b0, tail_mod} + SIZE_W'(1);
    if (tail_mod_inc == cfg.sq_size) begin
      full = (head_mod == '0);
    end else begin
      full = ({1'b0, head_mod} == tail_mod_inc);
    end
  end

  // Request decode and next state.
  always_comb begin
    sq_tail_ptr_next  = sq_tail_ptr;
    sq_head_ptr_next  = sq_head_ptr;
    sq_phase_bit_next = sq_phase_bit;
    sq_last_rung_next = sq_last_rung;
    cq_head_ptr_next  = cq_head_ptr;
    cq_phase_bit_next = cq_phase_bit;
    cq_last_rung_next = cq_last_rung;
    tail_mod_next     = tail_mod;
    head_mod_next     = head_mod;
    status_c = ST_OK;
    slot_c   = '0;
    cid_c    = '0;
    dbv_c    = 1'b0;
    dbval_c  = '0;

    if (stat.done) begin
      tail_mod_next = stat.tail_rem;
      head_mod_next = stat.head_rem;
    end

    if (req_fire) begin
      unique case (req_kind_t'(req.req_type))
        REQ_ENQUEUE: begin
          if (full) begin
            status_c = ST_FULL;
          end else begin
            slot_c            = sq_tail_ptr;
            sq_tail_ptr_next  = tail_bump;
            tail_mod_next     = tail_bump;
            sq_phase_bit_next = phase_new;
            cid_c = {1'b0, tail_bump} + (phase_new ? '0 : cfg.sq_size);
          end
        end
        REQ_SUBMIT: begin
          if (sq_last_rung != sq_tail_ptr) begin
            dbv_c             = 1'b1;
            dbval_c           = sq_tail_ptr;
            sq_last_rung_next = sq_tail_ptr;
          end
        end
        REQ_POLL, REQ_DEQUEUE: begin
          if (req.entry_phase != cq_phase_bit) begin
            status_c = ST_NOT_READY;
          end else begin
            slot_c = cq_head_ptr;
            if (req_kind_t'(req.req_type) == REQ_DEQUEUE) begin
              cq_head_ptr_next  = cq_bump;
              cq_phase_bit_next = cq_phase_bit ^ cq_wrap;
            end
          end
        end
        REQ_CQ_DOORBELL: begin
          if (cq_last_rung != cq_head_ptr) begin
            dbv_c             = 1'b1;
            dbval_c           = cq_head_ptr;
            cq_last_rung_next = cq_head_ptr;
          end
        end
        REQ_SQ_HEAD_CHECKED: begin
          if (!req.entry_present) begin
            status_c = ST_NOT_READY;
          end else if (req.entry_sqid != cfg.sq_ident) begin
            status_c = ST_BAD_QID;
          end else begin
            sq_head_ptr_next = head_bump;
            head_mod_next    = head_bump;
          end
        end
        REQ_SQ_HEAD_UNCHECKED: begin
          sq_head_ptr_next = head_bump;
          head_mod_next    = head_bump;
        end
        default: ;
      endcase
    end
  end

  // Pointer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tail_ptr  <= '0;
      sq_head_ptr  <= '0;
      sq_phase_bit <= 1'b1;
      sq_last_rung <= '0;
      cq_head_ptr  <= '0;
      cq_phase_bit <= 1'b1;
      cq_last_rung <= '0;
      tail_mod     <= '0;
      head_mod     <= '0;
    end else begin
      sq_tail_ptr  <= sq_tail_ptr_next;
      sq_head_ptr  <= sq_head_ptr_next;
      sq_phase_bit <= sq_phase_bit_next;
      sq_last_rung <= sq_last_rung_next;
      cq_head_ptr  <= cq_head_ptr_next;
      cq_phase_bit <= cq_phase_bit_next;
      cq_last_rung <= cq_last_rung_next;
      tail_mod     <= tail_mod_next;
      head_mod     <= head_mod_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      out_status <= status_c;
      out_slot   <= slot_c;
      out_cid    <= cid_c;
      out_dbv    <= dbv_c;
      out_dbval  <= dbval_c;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.slot_index     = out_slot;
  assign rsp.command_id     = out_cid;
  assign rsp.doorbell_valid = out_dbv;
  assign rsp.doorbell_value = out_dbval;

  // An accepted request always leaves a result behind.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> out_valid)
    else $error("accepted request produced no result");

  // A doorbell is only issued alongside an ok status.
  a_doorbell_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dbv) |-> (out_status == ST_OK))
    else $error("doorbell issued with a failing status");

  // A refused enqueue leaves the tail and phase alone.
  a_full_holds_tail: assert property (@(posedge clk) disable iff (rst)
    (req_fire && (req.req_type == REQ_ENQUEUE) && full)
      |=> ($stable(sq_tail_ptr) && $stable(sq_phase_bit)))
    else $error("tail moved on a full queue");

  // Once reduced, the tail stays inside the submission ring.
  a_tail_mod_range: assert property (@(posedge clk) disable iff (rst)
    !(cfg.resize || stat.busy || stat.done || $past(cfg.resize))
      |-> ({1'b0, tail_mod} < cfg.sq_size))
    else $error("reduced tail outside the ring");

  // No request is taken while the pointers are being reduced.
  a_no_fire_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !req_fire)
    else $error("request accepted during pointer reduction");

endmodule

// File: rtl/nvme_queue_pair_pointers.sv
// Top level of the NVMe queue pair pointer manager.
//
// Host-side pointers for one submission and completion queue pair. Requests
// arrive on the req channel (enqueue, submit doorbell, poll, dequeue,
// completion doorbell, checked and unchecked submission head update) and
// each produces exactly one result on the rsp channel: a status, a slot
// index, a command id and an optional doorbell write.
// rsp.valid rises in the cycle after acceptance; one request can be accepted
// in every cycle (barring a reduction or stalled result), since all pointer
// updates are a single increment and compare ahead of the result register.
// The result register frees up in the cycle it is taken, so a stalled
// receiver holds rsp steady and drops req.ready only while the result is
// still waiting.
// The APB port holds sq_entries, cq_entries and sq_ident at 0x0, 0x4, 0x8.
// Writing sq_entries starts a bit-serial reduction of the submission
// pointers by the new ring size; req.ready stays low for that write cycle,
// while the reduction is busy and while its done pulse is high.
// Reset (rst, synchronous) clears all pointers, sets both phase bits, and
// restores the register defaults; no clearing pass is needed.
module nvme_queue_pair_pointers import nqp_pkg::*; #(
  parameter int MAX_RING_DEPTH = MAX_RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  nqp_req_if.sink               req,
  nqp_rsp_if.source             rsp
);

  cfg_t             cfg;
  reduce_stat_t     stat;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W-1:0] head_ptr;

  // Configuration registers.
  nqp_cfg_regs #(
    .MAX_RING_DEPTH(MAX_RING_DEPTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pointer reduction after a submission ring resize.
  nqp_ptr_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .start    (cfg.resize),
    .tail_ptr (tail_ptr),
    .head_ptr (head_ptr),
    .divisor  (cfg.sq_size),
    .stat     (stat)
  );

  // Request handling and result stage.
  nqp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .stat     (stat),
    .tail_ptr (tail_ptr),
    .head_ptr (head_ptr),
    .req      (req),
    .rsp      (rsp)
  );

endmodule

// File: tb/sv/nvme_queue_pair_pointers_tb.sv
// Self-checking testbench for the NVMe queue pair pointer manager.
`timescale 1ns / 1ps

module nvme_queue_pair_pointers_tb;
  import nqp_pkg::*;

  // Request type with no function; the block must answer it with an empty result.
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PHASES = 12;
  localparam int REQUESTS_PER_PHASE = 96;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [2:0]      kind;
    logic            phase;
    logic            present;
    logic [ID_W-1:0] sqid;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [PTR_W-1:0] slot;
    logic [CID_W-1:0] cid;
    logic             db_valid;
    logic [PTR_W-1:0] db_value;
  } result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  nqp_req_if req_ch ();
  nqp_rsp_if rsp_ch ();

  nvme_queue_pair_pointers dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Shadow copy of the registers and pointer state.
  logic [SIZE_W-1:0] sq_entries_reg;
  logic [SIZE_W-1:0] cq_entries_reg;
  logic [ID_W-1:0]   sq_ident_reg;
  logic [PTR_W-1:0]  sq_tail;
  logic [PTR_W-1:0]  sq_head;
  logic              sq_phase;
  logic [PTR_W-1:0]  sq_rung;
  logic [PTR_W-1:0]  cq_head;
  logic              cq_phase;
  logic [PTR_W-1:0]  cq_rung;

  result_t expected_results[$];
  result_t got_result;
  result_t want_result;
  int      error_count;
  int      cycle_count;
  int      sink_stall_left;
  bit      source_steady;
  bit      sink_steady;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nvme_queue_pair_pointers_tb: errors");
      $finish;
    end
  end

  // Ring size in use: the register value clamped to the legal range.
  function automatic logic [SIZE_W-1:0] ring_size(logic [SIZE_W-1:0] reg_val);
    int lim;
    lim = (MAX_RING_DEPTH_DEF < PTR_SPAN) ? MAX_RING_DEPTH_DEF : PTR_SPAN;
    if (reg_val < RING_MIN) return SIZE_W'(RING_MIN);
    if (reg_val > lim) return SIZE_W'(lim);
    return reg_val;
  endfunction

  // Pointer increment; anything reaching the ring size goes back to zero.
  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p, logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] v;
    v = p + 13'd1;
    return (v >= n) ? '0 : v[PTR_W-1:0];
  endfunction

  // Works out the result of one accepted request and advances the shadow state.
  function automatic result_t predict_result(request_t rq);
    result_t r;
    logic [SIZE_W-1:0] nsq;
    logic [SIZE_W-1:0] ncq;
    logic [PTR_W-1:0]  nxt;
    int                used;
    r = '0;
    r.status = ST_OK;
    nsq = ring_size(sq_entries_reg);
    ncq = ring_size(cq_entries_reg);
    case (rq.kind)
      REQ_ENQUEUE: begin
        used = ((sq_tail % nsq) + nsq - (sq_head % nsq)) % nsq;
        if (used == nsq - 1) begin
          r.status = ST_FULL;
        end else begin
          r.slot = sq_tail;
          nxt = step_ptr(sq_tail, nsq);
          if (nxt == '0) sq_phase = ~sq_phase;
          sq_tail = nxt;
          r.cid = sq_tail + (sq_phase ? 13'd0 : nsq);
        end
      end
      REQ_SUBMIT: begin
        if (sq_rung != sq_tail) begin
          r.db_valid = 1'b1;
          r.db_value = sq_tail;
          sq_rung = sq_tail;
        end
      end
      REQ_POLL, REQ_DEQUEUE: begin
        if (rq.phase != cq_phase) begin
          r.status = ST_NOT_READY;
        end else begin
          r.slot = cq_head;
          if (rq.kind == REQ_DEQUEUE) begin
            nxt = step_ptr(cq_head, ncq);
            if (nxt == '0) cq_phase = ~cq_phase;
            cq_head = nxt;
          end
        end
      end
      REQ_CQ_DOORBELL: begin
        if (cq_rung != cq_head) begin
          r.db_valid = 1'b1;
          r.db_value = cq_head;
          cq_rung = cq_head;
        end
      end
      REQ_SQ_HEAD_CHECKED: begin
        if (!rq.present) r.status = ST_NOT_READY;
        else if (rq.sqid != sq_ident_reg) r.status = ST_BAD_QID;
        else sq_head = step_ptr(sq_head, nsq);
      end
      REQ_SQ_HEAD_UNCHECKED: begin
        sq_head = step_ptr(sq_head, nsq);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_ring_size();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd4097;
      4: return 13'd8191;
      5: return SIZE_W'($urandom_range(0, 8191));
      default: return SIZE_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] pick_ident();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r == 2) return '1;
    return ID_W'($urandom);
  endfunction

  // Mostly well-formed requests: matching phase, a completion present, right queue id.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) rq.kind = REQ_ENQUEUE;
    else if (pick < 38) rq.kind = REQ_SUBMIT;
    else if (pick < 48) rq.kind = REQ_POLL;
    else if (pick < 63) rq.kind = REQ_DEQUEUE;
    else if (pick < 70) rq.kind = REQ_CQ_DOORBELL;
    else if (pick < 85) rq.kind = REQ_SQ_HEAD_CHECKED;
    else if (pick < 95) rq.kind = REQ_SQ_HEAD_UNCHECKED;
    else rq.kind = REQ_UNUSED;
    rq.phase = ($urandom_range(0, 4) != 0) ? cq_phase : 1'($urandom_range(0, 1));
    rq.present = ($urandom_range(0, 6) != 0);
    rq.sqid = ($urandom_range(0, 4) != 0) ? sq_ident_reg : ID_W'($urandom);
    return rq;
  endfunction

  function automatic request_t make_request(logic [2:0] kind, logic phase, logic present,
                                            logic [ID_W-1:0] sqid);
    request_t rq;
    rq.kind = kind;
    rq.phase = phase;
    rq.present = present;
    rq.sqid = sqid;
    return rq;
  endfunction

  // Sends one request and records its expected result once accepted.
  task automatic send_request(request_t rq);
    @(negedge clk);
    req_ch.valid = 1'b1;
    req_ch.req_type = rq.kind;
    req_ch.entry_phase = rq.phase;
    req_ch.entry_present = rq.present;
    req_ch.entry_sqid = rq.sqid;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_results.push_back(predict_result(rq));
  endtask

  // Drops valid for a number of cycles.
  task automatic pause_source(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Lets the block drain, including the pointer reduction after a size write.
  task automatic settle();
    pause_source(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(cfg_reg_t idx, logic [APB_DATA_W-1:0] value);
    settle();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      CFG_SQ_ENTRIES: sq_entries_reg = value[SIZE_W-1:0];
      CFG_CQ_ENTRIES: cq_entries_reg = value[SIZE_W-1:0];
      CFG_SQ_IDENT:   sq_ident_reg = value[ID_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic note_error(string what, result_t want, result_t got);
    error_count++;
    if (error_count <= MAX_REPORTED) begin
      $display("%0t %s: want st=%0d slot=%0d cid=%0d db=%0b/%0d got st=%0d slot=%0d cid=%0d db=%0b/%0d",
               $realtime, what, want.status, want.slot, want.cid, want.db_valid, want.db_value,
               got.status, got.slot, got.cid, got.db_valid, got.db_value);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got_result.status = status_t'(rsp_ch.status);
      got_result.slot = rsp_ch.slot_index;
      got_result.cid = rsp_ch.command_id;
      got_result.db_valid = rsp_ch.doorbell_valid;
      got_result.db_value = rsp_ch.doorbell_value;
      if (expected_results.size() == 0) begin
        note_error("result with no request pending", '0, got_result);
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result) note_error("result mismatch", want_result, got_result);
      end
    end
  end

  // Receiver stalls, with stretches of none.
  initial begin
    rsp_ch.ready = 1'b0;
    sink_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ch.ready = 1'b0;
      end else if (sink_stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        sink_stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) sink_stall_left = gap_len();
      end
    end
  end

  // Every request type at least once at the reset configuration, with the id extremes.
  task automatic test_basic_requests();
    send_request(make_request(REQ_SUBMIT, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SUBMIT, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SUBMIT, 1'b1, 1'b1, 16'hFFFF));
    send_request(make_request(REQ_POLL, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_POLL, 1'b1, 1'b0, 16'h0000));
    send_request(make_request(REQ_DEQUEUE, 1'b1, 1'b0, 16'h0000));
    send_request(make_request(REQ_CQ_DOORBELL, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_CQ_DOORBELL, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SQ_HEAD_CHECKED, 1'b1, 1'b0, 16'h0001));
    send_request(make_request(REQ_SQ_HEAD_CHECKED, 1'b1, 1'b1, 16'hFFFF));
    send_request(make_request(REQ_SQ_HEAD_CHECKED, 1'b0, 1'b1, 16'h0001));
    send_request(make_request(REQ_SQ_HEAD_UNCHECKED, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_UNUSED, 1'b1, 1'b1, 16'hFFFF));
  endtask

  // Smallest rings: full refusal, tail wrap with phase flip, completion head wrap.
  task automatic test_ring_wrap();
    write_reg(CFG_SQ_ENTRIES, 32'd2);
    write_reg(CFG_CQ_ENTRIES, 32'd2);
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SQ_HEAD_UNCHECKED, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_DEQUEUE, cq_phase, 1'b0, 16'h0000));
    send_request(make_request(REQ_DEQUEUE, cq_phase, 1'b0, 16'h0000));
    send_request(make_request(REQ_POLL, ~cq_phase, 1'b0, 16'h0000));
    send_request(make_request(REQ_POLL, cq_phase, 1'b0, 16'h0000));
  endtask

  // Sizes outside the legal range and the queue id extremes.
  task automatic test_size_extremes();
    write_reg(CFG_SQ_ENTRIES, 32'd0);
    write_reg(CFG_CQ_ENTRIES, 32'd8191);
    write_reg(CFG_SQ_IDENT, 32'd0);
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SQ_HEAD_CHECKED, 1'b0, 1'b1, 16'h0000));
    write_reg(CFG_SQ_ENTRIES, 32'd4096);
    write_reg(CFG_SQ_IDENT, 32'd65535);
    send_request(make_request(REQ_ENQUEUE, 1'b0, 1'b0, 16'h0000));
    send_request(make_request(REQ_SQ_HEAD_CHECKED, 1'b0, 1'b1, 16'hFFFF));
  endtask

  // Random phases, each with a fresh configuration kept over live pointers.
  task automatic test_random_traffic();
    int counted;
    request_t rq;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_SQ_ENTRIES, 32'(pick_ring_size()));
      write_reg(CFG_CQ_ENTRIES, 32'(pick_ring_size()));
      write_reg(CFG_SQ_IDENT, 32'(pick_ident()));
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < REQUESTS_PER_PHASE) begin
        rq = random_request();
        send_request(rq);
        if (rq.kind != REQ_UNUSED) counted++;
        if (!source_steady) pause_source(gap_len());
      end
    end
    source_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ENQUEUE;
    req_ch.entry_phase = 1'b0;
    req_ch.entry_present = 1'b0;
    req_ch.entry_sqid = '0;
    error_count = 0;
    cycle_count = 0;
    source_steady = 1'b0;
    sink_steady = 1'b0;
    sq_entries_reg = SQ_ENTRIES_RST;
    cq_entries_reg = CQ_ENTRIES_RST;
    sq_ident_reg = SQ_IDENT_RST;
    sq_tail = '0;
    sq_head = '0;
    sq_phase = 1'b1;
    sq_rung = '0;
    cq_head = '0;
    cq_phase = 1'b1;
    cq_rung = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_requests();
    test_ring_wrap();
    test_size_extremes();
    test_random_traffic();

    // Drain and let the last result settle.
    pause_source(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("nvme_queue_pair_pointers_tb: clean");
    end else begin
      $display("nvme_queue_pair_pointers_tb: errors");
    end
    $finish;
  end

endmodule
